### sv/lrr_pkg.sv
// Shared types and constants for the ranged LCG random unit.
`timescale 1ns / 1ps
`default_nettype none
package lrr_pkg;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ACTION_W = 3;

  localparam logic [ACTION_W-1:0] ACT_RAW      = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_U_ONE    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_U_RANGE  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_S_ONE    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_S_RANGE  = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_RESTART  = 3'd5;

  localparam logic [WORD_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_ADD = 32'd1013904223;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic load_seed;
    logic advance;
    logic restart;
  } lcg_ctrl_t;
endpackage
`default_nettype wire

### sv/lrr_lcg.sv
// Seed and generator state registers with the multiply-add step.
`timescale 1ns / 1ps
`default_nettype none
module lrr_lcg
  import lrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lcg_ctrl_t         ctrl,
  input  wire logic [WORD_W-1:0] seed_in,
  output logic      [WORD_W-1:0] seed,
  output logic      [WORD_W-1:0] cur,
  output logic      [WORD_W-1:0] cur_next
);
  logic [WORD_W-1:0] product;

  assign product  = LCG_MUL * cur;
  assign cur_next = product + LCG_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      cur  <= '0;
    end else if (ctrl.load_seed) begin
      seed <= seed_in;
      cur  <= seed_in;
    end else if (ctrl.restart) begin
      cur <= seed;
    end else if (ctrl.advance) begin
      cur <= cur_next;
    end
  end
endmodule
`default_nettype wire

### sv/lrr_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lrr_div
  import lrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W:0]   divisor,
  output div_status_t            status,
  output logic      [WORD_W-1:0] rem
);
  localparam int unsigned Steps = WORD_W;
  localparam int unsigned CntW  = $clog2(Steps);

  logic [WORD_W-1:0] dvd;
  logic [WORD_W:0]   dvs;
  logic [CntW-1:0]   cnt;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;

  assign trial = {rem, dvd[WORD_W-1]};
  assign diff  = trial - dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= 1'b0;
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= '0;
      end else if (status.busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(Steps - 1)) begin
          status.busy <= 1'b0;
          status.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (status.busy) begin
      dvd <= {dvd[WORD_W-2:0], 1'b0};
      if (!diff[WORD_W]) begin
        rem <= diff[WORD_W-1:0];
      end else begin
        rem <= trial[WORD_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

### sv/lcg_ranged_random_unit.sv
// Top level: ranged LCG random unit with action sequencer and output register.
//
// A 32-bit linear congruential generator (next = 1664525*cur + 1013904223 mod 2^32)
// serving one action per input beat: raw value, unsigned or signed 1..max or
// min..max, or restart from the seed. Ranged actions reduce the new state by a
// remainder unit that resolves one bit per cycle, so a ranged beat passes through
// evaluate, the remainder steps, the offset add into the result register and the
// output load; raw, restart, degenerate ranges and undefined actions go from
// evaluate straight to the output load. The input is not ready while a beat is at
// work and is ready again the cycle after the result is loaded, so a new beat is
// accepted only after the last result has been loaded. A result waits in the
// output register until taken, and the next result holds in the sequencer
// meanwhile; writing the seed also loads the generator state.
`timescale 1ns / 1ps
`default_nettype none
module lcg_ranged_random_unit
  import lrr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              seed_we,
  input  wire logic [WORD_W-1:0] seed_wdata,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [63:0]       s_tdata,   // range_min[31:0], range_max[63:32]
  input  wire logic [2:0]        s_tuser,   // action[2:0]
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [31:0]       m_tdata    // value[31:0]
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]          state;
  logic [ACTION_W-1:0] action;
  logic [WORD_W-1:0]   rmin;
  logic [WORD_W-1:0]   rmax;
  logic [WORD_W-1:0]   offset;
  logic [WORD_W-1:0]   result;

  lcg_ctrl_t           lcg_ctrl;
  logic [WORD_W-1:0]   seed;
  logic [WORD_W-1:0]   cur;
  logic [WORD_W-1:0]   cur_next;

  logic                div_start;
  logic [WORD_W:0]     span;
  div_status_t         div_stat;
  logic [WORD_W-1:0]   rem;

  logic [WORD_W:0]     span_u;
  logic [WORD_W:0]     span_s;
  logic                degen;
  logic                ranged;

  assign span_u = {1'b0, rmax} - {1'b0, rmin} + 1'b1;
  assign span_s = {rmax[WORD_W-1], rmax} - {rmin[WORD_W-1], rmin} + 1'b1;

  always_comb begin
    degen  = 1'b0;
    ranged = 1'b0;
    span   = {1'b0, rmax};
    case (action)
      ACT_U_ONE: begin
        degen  = (rmax == '0);
        ranged = 1'b1;
      end
      ACT_S_ONE: begin
        degen  = rmax[WORD_W-1] || (rmax == '0);
        ranged = 1'b1;
      end
      ACT_U_RANGE: begin
        degen  = (rmax <= rmin);
        ranged = 1'b1;
        span   = span_u;
      end
      ACT_S_RANGE: begin
        degen  = ($signed(rmax) <= $signed(rmin));
        ranged = 1'b1;
        span   = span_s;
      end
      default: begin
        degen  = 1'b0;
        ranged = 1'b0;
      end
    endcase
  end

  assign s_tready  = (state == ST_IDLE);
  assign div_start = (state == ST_EVAL) && ranged && !degen;

  always_comb begin
    lcg_ctrl.load_seed = seed_we;
    lcg_ctrl.restart   = (state == ST_EVAL) && (action == ACT_RESTART);
    lcg_ctrl.advance   = (state == ST_EVAL) &&
                         ((action == ACT_RAW) || (ranged && !degen));
  end

  lrr_lcg u_lcg (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (lcg_ctrl),
    .seed_in  (seed_wdata),
    .seed     (seed),
    .cur      (cur),
    .cur_next (cur_next)
  );

  lrr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur_next),
    .divisor  (span),
    .status   (div_stat),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (div_start) begin
            state <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      action <= s_tuser;
      rmin   <= s_tdata[31:0];
      rmax   <= s_tdata[63:32];
    end
    if (state == ST_EVAL) begin
      if ((action == ACT_U_ONE) || (action == ACT_S_ONE)) begin
        offset <= {{(WORD_W-1){1'b0}}, 1'b1};
      end else begin
        offset <= rmin;
      end
      case (action)
        ACT_RAW:     result <= cur_next;
        ACT_RESTART: result <= seed;
        ACT_U_RANGE: result <= rmin;
        ACT_S_RANGE: result <= rmin;
        default:     result <= '0;
      endcase
    end
    if (div_stat.done) begin
      result <= rem + offset;
    end
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= result;
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_DIV))
    else $error("remainder finished outside the divide phase");

  a_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == ST_DIV))
    else $error("remainder unit busy outside the divide phase");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!seed_we && (state != ST_EVAL)) |=> $stable(cur))
    else $error("generator state moved without an action or seed write");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> !s_tready)
    else $error("input ready while a beat is at work");
endmodule
`default_nettype wire
